FILE: sv/int2dec_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
// Used by the top level and by its checker; depends on nothing else.
`default_nettype none

package int2dec_pkg;

    localparam int VALUE_W    = 64;
    localparam int PAD_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    // Twenty decimal digits hold any 64-bit magnitude.
    localparam int NUM_DIGITS = 20;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam int DEFAULT_MAX_PAD_WIDTH = 20;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PAD_W-1:0]          pad_width;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_out_item;

endpackage

`default_nettype wire

FILE: sv/integer_to_decimal_ascii.sv
// Top level: signed 64-bit integer to decimal ASCII text, one character per strobe.
// Uses int2dec_pkg for the transaction types and character constants.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------
//  input   | start, busy        | i_in     (value, pad_width)
//  result  | o_valid (strobe)   | o_result (character, last)
//
// A transaction is taken at an edge with start high and busy low. The magnitude then
// goes through a bit-serial double-dabble register, one binary bit per cycle. A sign step
// follows for the optional '-', then one digit position per cycle, from the
// highest position down to the units; leading zeros in natural mode take a step but
// give no strobe. N positions are emitted: the padded width capped at MAX_PAD_WIDTH,
// or 20 in natural mode. Reset returns to idle at once; results cannot be stalled.
`default_nettype none

module integer_to_decimal_ascii #(
    parameter int MAX_PAD_WIDTH = int2dec_pkg::DEFAULT_MAX_PAD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  int2dec_pkg::t_in_item i_in,
    output logic                  busy,
    output logic                  o_valid,
    output int2dec_pkg::t_out_item o_result
);
    import int2dec_pkg::*;

    localparam int POS_W = $clog2(MAX_PAD_WIDTH);
    localparam int SAT_W = POS_W + 1;
    localparam int BCD_W = NUM_DIGITS * DIGIT_W;

    localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ       = 4'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                               r_state;
    logic [VALUE_W-1:0]                   r_bin;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   r_bcd;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   n_bcd;
    logic [BIT_CNT_W-1:0]                 r_bit;
    logic [POS_W-1:0]                     r_pos;
    logic                                 r_neg;
    logic                                 r_natural;
    logic                                 r_seen;
    logic                                 r_valid;
    t_out_item                            r_result;

    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   adj;
    logic [BCD_W-1:0]                     adj_flat;
    logic [VALUE_W-1:0]                   mag;
    logic [SAT_W-1:0]                     pad_sat;
    logic [POS_W-1:0]                     pos_start;
    logic [DIGIT_W-1:0]                   cur_digit;
    logic                                 suppress;

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Magnitude as unsigned, so the most negative value needs no special handling.
    assign mag = i_in.value[VALUE_W-1] ? (~i_in.value + 1'b1) : i_in.value;

    always_comb begin
        if (SAT_W'(i_in.pad_width) > SAT_W'(MAX_PAD_WIDTH)) begin
            pad_sat = SAT_W'(MAX_PAD_WIDTH);
        end else begin
            pad_sat = SAT_W'(i_in.pad_width);
        end
        if (i_in.pad_width == '0) begin
            pos_start = POS_W'(NUM_DIGITS - 1);
        end else begin
            pos_start = POS_W'(pad_sat - 1'b1);
        end
    end

    // Double-dabble step: correct every BCD digit, then shift in the next binary bit.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i] >= BCD_ADJ_LIMIT) begin
                adj[i] = r_bcd[i] + BCD_ADJ;
            end else begin
                adj[i] = r_bcd[i];
            end
        end
        adj_flat = adj;
        n_bcd    = {adj_flat[BCD_W-2:0], r_bin[VALUE_W-1]};
    end

    // Positions above the twentieth digit are always zero.
    always_comb begin
        if ({1'b0, r_pos} < SAT_W'(NUM_DIGITS)) begin
            cur_digit = r_bcd[r_pos[DIG_IDX_W-1:0]];
        end else begin
            cur_digit = '0;
        end
        suppress = r_natural && !r_seen && (cur_digit == '0) && (r_pos != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_bin     <= mag;
                        r_bcd     <= '0;
                        r_bit     <= '0;
                        r_neg     <= i_in.value[VALUE_W-1];
                        r_natural <= (i_in.pad_width == '0);
                        r_pos     <= pos_start;
                        r_seen    <= 1'b0;
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_bcd <= n_bcd;
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == BIT_CNT_W'(VALUE_W - 1)) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    if (r_neg) begin
                        r_valid            <= 1'b1;
                        r_result.character <= CHAR_MINUS;
                        r_result.last      <= 1'b0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!suppress) begin
                        r_valid            <= 1'b1;
                        r_result.character <= CHAR_ZERO + CHAR_W'(cur_digit);
                        r_result.last      <= (r_pos == '0);
                        r_seen             <= 1'b1;
                    end
                    if (r_pos == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= r_pos - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/int2dec_chk.sv
// Port-level checker for integer_to_decimal_ascii, bound to the top level.
// Uses int2dec_pkg for the result type and character constants.
`default_nettype none

module int2dec_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_valid,
    input int2dec_pkg::t_out_item o_result
);
    import int2dec_pkg::*;

    // A transaction that is taken keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted transaction");

    // Results only come out of work in progress.
    a_valid_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.character == CHAR_MINUS) ||
                    ((o_result.character >= CHAR_ZERO) && (o_result.character <= CHAR_NINE)))
        else $error("result character is neither a minus sign nor a digit");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.character == CHAR_MINUS) |-> !o_result.last)
        else $error("minus sign flagged as last character");

    // The final character appears exactly when the block goes idle.
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_valid && o_result.last)
        else $error("block went idle without the last character");

endmodule

bind integer_to_decimal_ascii int2dec_chk u_int2dec_chk (.*);

`default_nettype wire
